>>> sv/hst_pkg.sv
// Shared constants, operation codes and helpers of the hourly statistics engine.
// Depends on nothing; imported by the top level.
package hst_pkg;

  // Store geometry.
  localparam int NUM_SETS      = 8;
  localparam int HOURS_PER_SET = 24;
  localparam int STORE_DEPTH   = NUM_SETS * HOURS_PER_SET;
  localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SET_W         = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int HOUR_W        = (HOURS_PER_SET > 1) ? $clog2(HOURS_PER_SET) : 1;
  localparam int CNT_W         = $clog2(HOURS_PER_SET + 1);

  // Quartile threshold: three quarters of the hours in a set.
  localparam int QUARTILE_COUNT = (HOURS_PER_SET * 3) / 4;

  // Byte codes.
  localparam logic [7:0] UNSET_BYTE   = 8'hff;
  localparam logic [7:0] HOUR_CURRENT = 8'hff;

  // Operation codes.
  localparam logic [3:0] F_READ   = 4'd0;
  localparam logic [3:0] F_WRITE  = 4'd1;
  localparam logic [3:0] F_SMOOTH = 4'd2;
  localparam logic [3:0] F_COUNT  = 4'd3;
  localparam logic [3:0] F_MIN    = 4'd4;
  localparam logic [3:0] F_MAX    = 4'd5;
  localparam logic [3:0] F_TOP    = 4'd6;
  localparam logic [3:0] F_BOTTOM = 4'd7;
  localparam logic [3:0] F_CLEAR  = 4'd8;

  // Register indexes and reset values.
  localparam logic       REG_SMOOTH_SHIFT   = 1'b0;
  localparam logic [2:0] SMOOTH_SHIFT_RESET = 3'd3;

  // Reduce the clock hour into the range of one set; a small constant table.
  function automatic logic [HOUR_W-1:0] hour_mod(input logic [4:0] c);
    logic [HOUR_W-1:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (c == 5'(i)) begin
        r = HOUR_W'(i % HOURS_PER_SET);
      end
    end
    return r;
  endfunction

endpackage

>>> sv/hst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used by the top level for the sample store.
module hst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hourly_stats_table_engine.sv
// Top level of the hourly statistics engine: sequencer, shared compare unit, config port.
// Depends on hst_pkg and hst_ram.
//
//   channel   | handshake              | payload
//   ----------+------------------------+-------------------------------------------------
//   request   | start / busy           | func, stats_set, hour, operand_value,
//             |                        | current_hour, random_bits
//   result    | done (one-cycle strobe)| value, flag, bad_set
//   config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// A request is taken when start is high and busy is low; busy stays high until the result.
// Write, clear, unused codes and bad sets end at look-up, read at the reference check; smooth
// then calculates and writes back; count/min/max scan; quartile tests scan unless the named sample is unset.
// Scans read one sample per cycle from the store RAM.
// Reset empties the store at once through per-entry valid bits and sets smooth_shift to 3.
// The result strobe cannot be held off; the next request may be given in its cycle.
module hourly_stats_table_engine import hst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func,
  input  logic [3:0]  stats_set,
  input  logic [7:0]  hour,
  input  logic [7:0]  operand_value,
  input  logic [4:0]  current_hour,
  input  logic [7:0]  random_bits,
  output logic        done,
  output logic [7:0]  value,
  output logic        flag,
  output logic        bad_set,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_REFCHK = 3'd2;
  localparam logic [2:0] S_CALC   = 3'd3;
  localparam logic [2:0] S_WB     = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;

  logic [2:0]             state;
  logic [3:0]             op_func;
  logic                   op_bad;
  logic [ADDR_W-1:0]      base;
  logic [HOUR_W-1:0]      hh;
  logic [7:0]             opv;
  logic [7:0]             rnd;
  logic [7:0]             ref_val;
  logic [15:0]            acc;
  logic [HOUR_W-1:0]      scan_idx;
  logic                   scan_issue;
  logic                   pend;
  logic [CNT_W-1:0]       cnt;
  logic [7:0]             best;
  logic                   q_done;
  logic                   q_flag;
  logic [STORE_DEPTH-1:0] vld;
  logic                   vld_q;
  logic [2:0]             smooth_shift;

  logic [HOUR_W-1:0]      now_hour;
  logic [HOUR_W-1:0]      next_hour;
  logic [HOUR_W-1:0]      hour_sel;
  logic                   req_bad;
  logic                   accept;
  logic                   cfg_write;
  logic [ADDR_W-1:0]      raddr;
  logic [ADDR_W-1:0]      waddr;
  logic                   mem_we;
  logic [7:0]             mem_wdata;
  logic [7:0]             rdata;
  logic [7:0]             samp;
  logic [7:0]             cmp_b;
  logic                   lt;
  logic                   gt;
  logic [CNT_W-1:0]       cnt_upd;
  logic [7:0]             best_upd;
  logic                   q_done_upd;
  logic                   q_flag_upd;
  logic [7:0]             round_mask;
  logic [7:0]             smooth_res;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  // Configuration register: write on the access phase, read back the shift.
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_SMOOTH_SHIFT) ? {29'd0, smooth_shift} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_shift <= SMOOTH_SHIFT_RESET;
    end else if (cfg_write && paddr[2] == REG_SMOOTH_SHIFT) begin
      smooth_shift <= pwdata[2:0];
    end
  end

  // Hour selection: the named hour, the current hour or the next one.
  always_comb begin
    now_hour  = hour_mod(current_hour);
    next_hour = (now_hour == HOUR_W'(HOURS_PER_SET - 1)) ? '0 : now_hour + 1'b1;
    if (hour == HOUR_CURRENT) begin
      hour_sel = now_hour;
    end else if (hour >= 8'(HOURS_PER_SET)) begin
      hour_sel = next_hour;
    end else begin
      hour_sel = hour[HOUR_W-1:0];
    end
  end

  assign req_bad = (func <= F_BOTTOM) && ({1'b0, stats_set} >= 5'(NUM_SETS));

  // Store addressing; the scan walks the set, everything else uses the selected hour.
  assign raddr = (state == S_SCAN) ? base + ADDR_W'(scan_idx) : base + ADDR_W'(hh);
  assign waddr = base + ADDR_W'(hh);

  // Unwritten entries read as unset.
  assign samp = vld_q ? rdata : UNSET_BYTE;

  // Smoothing: final right shift of the accumulated sum.
  assign round_mask = (8'd1 << smooth_shift) - 8'd1;
  assign smooth_res = 8'(acc >> smooth_shift);

  // Store writes happen for write requests and the smoothing write-back.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = opv;
    if (state == S_LOOK && !op_bad && op_func == F_WRITE) begin
      mem_we = 1'b1;
    end else if (state == S_WB) begin
      mem_we    = 1'b1;
      mem_wdata = smooth_res;
    end
  end

  hst_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shared compare unit: one magnitude compare against the operand the operation needs.
  always_comb begin
    unique case (op_func)
      F_COUNT:      cmp_b = opv;
      F_MIN, F_MAX: cmp_b = best;
      default:      cmp_b = ref_val;
    endcase
    lt = (samp < cmp_b);
    gt = (samp > cmp_b);
  end

  // Accumulator update for one scanned sample.
  always_comb begin
    cnt_upd    = cnt;
    best_upd   = best;
    q_done_upd = q_done;
    q_flag_upd = q_flag;
    unique case (op_func)
      F_COUNT: begin
        if (lt) begin
          cnt_upd = cnt + 1'b1;
        end
      end
      F_MIN: begin
        if (lt) begin
          best_upd = samp;
        end
      end
      F_MAX: begin
        if (samp != UNSET_BYTE && (best == UNSET_BYTE || gt)) begin
          best_upd = samp;
        end
      end
      F_TOP, F_BOTTOM: begin
        if (!q_done) begin
          if (samp == UNSET_BYTE) begin
            q_done_upd = 1'b1;
          end else if ((op_func == F_TOP) ? lt : gt) begin
            cnt_upd = cnt + 1'b1;
            if (cnt_upd >= CNT_W'(QUARTILE_COUNT)) begin
              q_done_upd = 1'b1;
              q_flag_upd = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Valid bits: cleared by reset and clear-all, set by every store write.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (state == S_LOOK && !op_bad && op_func == F_CLEAR) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[waddr] <= 1'b1;
    end
    vld_q <= vld[raddr];
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (op_bad || op_func == F_WRITE || op_func > F_BOTTOM) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else if (op_func == F_COUNT || op_func == F_MIN || op_func == F_MAX) begin
            state <= S_SCAN;
          end else begin
            state <= S_REFCHK;
          end
        end
        S_REFCHK: begin
          if (op_func == F_SMOOTH) begin
            state <= S_CALC;
          end else if (op_func == F_READ || samp == UNSET_BYTE) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_SCAN;
          end
        end
        S_CALC: begin
          state <= S_WB;
        end
        S_WB: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_SCAN: begin
          if (pend && !scan_issue) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Sequencer datapath and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_func    <= func;
        op_bad     <= req_bad;
        base       <= ADDR_W'(stats_set[SET_W-1:0]) * ADDR_W'(HOURS_PER_SET);
        hh         <= hour_sel;
        opv        <= operand_value;
        rnd        <= random_bits;
        scan_idx   <= '0;
        scan_issue <= 1'b1;
        pend       <= 1'b0;
        cnt        <= '0;
        best       <= UNSET_BYTE;
        q_done     <= 1'b0;
        q_flag     <= 1'b0;
      end
      S_LOOK: begin
        bad_set <= op_bad;
        flag    <= 1'b0;
        if (op_bad) begin
          value <= UNSET_BYTE;
        end else if (op_func == F_WRITE) begin
          value <= opv;
        end else begin
          value <= 8'd0;
        end
      end
      S_REFCHK: begin
        ref_val <= samp;
        value   <= (op_func == F_READ) ? samp : 8'd0;
        flag    <= 1'b0;
        bad_set <= 1'b0;
      end
      S_CALC: begin
        acc <= ({8'd0, ref_val} << smooth_shift) - {8'd0, ref_val} + {8'd0, opv}
               + {8'd0, rnd & round_mask};
      end
      S_WB: begin
        value   <= smooth_res;
        flag    <= 1'b0;
        bad_set <= 1'b0;
      end
      S_SCAN: begin
        if (scan_issue) begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == HOUR_W'(HOURS_PER_SET - 1)) begin
            scan_issue <= 1'b0;
          end
        end
        pend <= scan_issue;
        if (pend) begin
          cnt    <= cnt_upd;
          best   <= best_upd;
          q_done <= q_done_upd;
          q_flag <= q_flag_upd;
          if (!scan_issue) begin
            bad_set <= 1'b0;
            unique case (op_func)
              F_COUNT: begin
                value <= 8'(cnt_upd);
                flag  <= 1'b0;
              end
              F_MIN, F_MAX: begin
                value <= best_upd;
                flag  <= 1'b0;
              end
              default: begin
                value <= 8'd0;
                flag  <= q_flag_upd;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // A result is only strobed once the sequencer is back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while sequencer busy");

  // An accepted request makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not start the sequencer");

  // Busy only drops together with a result strobe.
  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("request finished without a result");

  // A quartile test never reports a nonzero value for a valid set.
  a_flag_value: assert property (@(posedge clk) disable iff (rst)
    done && flag |-> value == 8'd0 && !bad_set)
    else $error("quartile result carries a value");
`endif

endmodule

>>> verif/tb_hourly_stats_table_engine.sv
// Self-checking testbench of hourly_stats_table_engine: directed and random requests,
// each result checked against an in-bench model of the statistics store.
// Depends on hst_pkg and the engine RTL.
module tb_hourly_stats_table_engine import hst_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes with no function, and the register address.
  localparam logic [3:0] F_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] F_LAST_UNUSED  = 4'd15;
  localparam logic [2:0] SHIFT_ADDR     = 3'({REG_SMOOTH_SHIFT, 2'b00});
  localparam int         IDLE_LIMIT     = 1000;
  localparam int         ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic [3:0] func;
    logic [3:0] stats_set;
    logic [7:0] hour;
    logic [7:0] operand_value;
    logic [4:0] current_hour;
    logic [7:0] random_bits;
  } stats_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       flag;
    logic       bad_set;
  } stats_outcome_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  func;
  logic [3:0]  stats_set;
  logic [7:0]  hour;
  logic [7:0]  operand_value;
  logic [4:0]  current_hour;
  logic [7:0]  random_bits;
  logic        done;
  logic [7:0]  value;
  logic        flag;
  logic        bad_set;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Model of the store and the smoothing register.
  logic [7:0]     sample_model [0:STORE_DEPTH-1];
  logic [2:0]     model_shift;
  stats_outcome_t pending_outcomes [$];

  int mismatches = 0;
  int transfers  = 0;
  int seen_transfers = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  hourly_stats_table_engine i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .stats_set(stats_set), .hour(hour), .operand_value(operand_value),
    .current_hour(current_hour), .random_bits(random_bits),
    .done(done), .value(value), .flag(flag), .bad_set(bad_set),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5ns clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    mismatches++;
    $display("MISMATCH %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
  endtask

  function automatic stats_req_t make_req(input logic [3:0] f, input logic [3:0] s,
                                          input logic [7:0] h, input logic [7:0] v,
                                          input logic [4:0] c, input logic [7:0] rb);
    stats_req_t r;
    r.func = f;
    r.stats_set = s;
    r.hour = h;
    r.operand_value = v;
    r.current_hour = c;
    r.random_bits = rb;
    return r;
  endfunction

  // Works out the result of one request and applies it to the model store.
  task automatic predict_outcome(input stats_req_t r, output stats_outcome_t o);
    int          now;
    int          hh;
    int          base;
    int          below;
    logic [15:0] mask;
    logic [15:0] acc;
    logic [7:0]  ref_sample;
    logic [7:0]  smp;
    now = int'(r.current_hour) % HOURS_PER_SET;
    if (r.hour == HOUR_CURRENT) begin
      hh = now;
    end else if (int'(r.hour) >= HOURS_PER_SET) begin
      hh = (now + 1) % HOURS_PER_SET;
    end else begin
      hh = int'(r.hour);
    end
    o = '0;
    if (r.func <= F_BOTTOM && int'(r.stats_set) >= NUM_SETS) begin
      o.bad_set = 1'b1;
      o.value = UNSET_BYTE;
    end else if (r.func <= F_BOTTOM) begin
      base = int'(r.stats_set) * HOURS_PER_SET;
      case (r.func)
        F_READ: begin
          o.value = sample_model[base + hh];
        end
        F_WRITE: begin
          sample_model[base + hh] = r.operand_value;
          o.value = r.operand_value;
        end
        F_SMOOTH: begin
          mask = (16'd1 << model_shift) - 16'd1;
          acc = (16'(sample_model[base + hh]) << model_shift) - 16'(sample_model[base + hh])
                + 16'(r.operand_value) + (16'(r.random_bits) & mask);
          o.value = 8'(acc >> model_shift);
          sample_model[base + hh] = o.value;
        end
        F_COUNT: begin
          for (int h = 0; h < HOURS_PER_SET; h++) begin
            if (sample_model[base + h] < r.operand_value) begin
              o.value = o.value + 8'd1;
            end
          end
        end
        F_MIN: begin
          o.value = UNSET_BYTE;
          for (int h = 0; h < HOURS_PER_SET; h++) begin
            if (sample_model[base + h] < o.value) begin
              o.value = sample_model[base + h];
            end
          end
        end
        F_MAX: begin
          o.value = UNSET_BYTE;
          for (int h = 0; h < HOURS_PER_SET; h++) begin
            smp = sample_model[base + h];
            if (smp != UNSET_BYTE && (o.value == UNSET_BYTE || smp > o.value)) begin
              o.value = smp;
            end
          end
        end
        default: begin
          // Quartile tests scan upward and give up on the first unset sample.
          ref_sample = sample_model[base + hh];
          below = 0;
          if (ref_sample != UNSET_BYTE) begin
            for (int h = 0; h < HOURS_PER_SET; h++) begin
              smp = sample_model[base + h];
              if (smp == UNSET_BYTE) begin
                break;
              end
              if ((r.func == F_TOP) ? (smp < ref_sample) : (smp > ref_sample)) begin
                below++;
                if (below >= QUARTILE_COUNT) begin
                  o.flag = 1'b1;
                  break;
                end
              end
            end
          end
        end
      endcase
    end else if (r.func == F_CLEAR) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        sample_model[i] = UNSET_BYTE;
      end
    end
  endtask

  // Sends one request; returns at the clock edge of its transfer with start still high.
  task automatic send_request(input stats_req_t r);
    stats_outcome_t o;
    if (gaps_on && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 30)) begin
        @(posedge clk);
      end
    end
    start <= 1'b1;
    func <= r.func;
    stats_set <= r.stats_set;
    hour <= r.hour;
    operand_value <= r.operand_value;
    current_hour <= r.current_hour;
    random_bits <= r.random_bits;
    do @(negedge clk); while (busy);
    predict_outcome(r, o);
    pending_outcomes.push_back(o);
    transfers++;
    @(posedge clk);
  endtask

  // Lowers start and waits until every expected result has come back.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending_outcomes.size() != 0 || busy);
    @(posedge clk);
  endtask

  // Writes the smoothing shift, then reads it back.
  task automatic set_smooth_shift(input logic [2:0] s);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SHIFT_ADDR;
    pwdata <= 32'(s);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    model_shift = s;
    transfers++;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    if (prdata[2:0] !== s) begin
      report_mismatch("smooth_shift readback", 32'(s), prdata);
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] random_hour();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return 8'($urandom_range(0, HOURS_PER_SET - 1));
    end else if (pick < 80) begin
      return HOUR_CURRENT;
    end
    return 8'($urandom_range(HOURS_PER_SET, 254));
  endfunction

  function automatic logic [4:0] random_clock_hour();
    return ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 23)) : 5'($urandom_range(24, 31));
  endfunction

  // A fresh store reads as unset everywhere.
  task automatic test_reset_contents();
    send_request(make_req(F_READ, 4'd0, 8'd0, 8'd0, 5'd0, 8'd0));
    send_request(make_req(F_MIN, 4'd7, 8'd0, 8'd0, 5'd0, 8'd0));
    send_request(make_req(F_MAX, 4'd7, 8'd0, 8'd0, 5'd0, 8'd0));
    send_request(make_req(F_COUNT, 4'd3, 8'd0, 8'hff, 5'd0, 8'd0));
    send_request(make_req(F_TOP, 4'd0, 8'd5, 8'd0, 5'd0, 8'd0));
  endtask

  // Single-sample access, hour selection, invalid sets and unused codes.
  task automatic test_sample_access();
    send_request(make_req(F_WRITE, 4'd0, 8'd0, 8'h00, 5'd0, 8'd0));
    send_request(make_req(F_WRITE, 4'd7, HOUR_CURRENT, 8'hfe, 5'd23, 8'd0));
    send_request(make_req(F_READ, 4'd7, 8'd24, 8'd0, 5'd22, 8'd0));
    // The next hour after the last one wraps to hour 0.
    send_request(make_req(F_WRITE, 4'd1, 8'd200, 8'h80, 5'd23, 8'd0));
    send_request(make_req(F_READ, 4'd1, 8'd0, 8'd0, 5'd0, 8'd0));
    send_request(make_req(F_READ, 4'd1, HOUR_CURRENT, 8'd0, 5'd31, 8'hff));
    send_request(make_req(F_WRITE, 4'd8, 8'd0, 8'h55, 5'd0, 8'd0));
    send_request(make_req(F_READ, 4'd15, 8'd0, 8'd0, 5'd0, 8'd0));
    send_request(make_req(F_BOTTOM, 4'd9, 8'd0, 8'd0, 5'd0, 8'd0));
    send_request(make_req(F_FIRST_UNUSED, 4'd0, 8'd0, 8'hff, 5'd0, 8'd0));
    send_request(make_req(F_LAST_UNUSED, 4'd15, 8'hff, 8'hff, 5'd31, 8'hff));
    send_request(make_req(F_COUNT, 4'd0, 8'd0, 8'h00, 5'd0, 8'd0));
    send_request(make_req(F_COUNT, 4'd0, 8'd0, 8'h01, 5'd0, 8'd0));
    send_request(make_req(F_MIN, 4'd0, 8'd0, 8'd0, 5'd0, 8'd0));
    send_request(make_req(F_MAX, 4'd7, 8'd0, 8'd0, 5'd0, 8'd0));
  endtask

  // Smoothing of an unset sample, then a full clear of the store.
  task automatic test_smoothing_and_clear();
    send_request(make_req(F_SMOOTH, 4'd2, 8'd3, 8'h00, 5'd0, 8'hff));
    send_request(make_req(F_SMOOTH, 4'd2, 8'd3, 8'hff, 5'd0, 8'h00));
    send_request(make_req(F_CLEAR, 4'd15, 8'd0, 8'd0, 5'd0, 8'd0));
    send_request(make_req(F_READ, 4'd0, 8'd0, 8'd0, 5'd0, 8'd0));
  endtask

  // Random traffic in phases with different smoothing shifts.
  task automatic test_random_traffic();
    int         sent;
    int         base;
    logic [3:0] s;
    logic [3:0] f;
    logic [7:0] v;
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: set_smooth_shift(3'd7);
        1: set_smooth_shift(3'd1);
        2: set_smooth_shift(3'd0);
        default: set_smooth_shift(3'($urandom_range(1, 7)));
      endcase
      // One phase runs with no gaps at all.
      gaps_on = (phase != 1);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 60) begin
          // Fill one set with close values, then query it.
          s = 4'($urandom_range(0, NUM_SETS - 1));
          base = $urandom_range(0, 230);
          for (int h = 0; h < HOURS_PER_SET; h++) begin
            v = ($urandom_range(0, 99) < 4) ? UNSET_BYTE : 8'(base + $urandom_range(0, 24));
            send_request(make_req(F_WRITE, s, 8'(h), v, random_clock_hour(), 8'($urandom)));
          end
          for (int q = 0; q < 6; q++) begin
            f = 4'($urandom_range(F_READ, F_BOTTOM));
            send_request(make_req(f, s, random_hour(), 8'(base + $urandom_range(0, 30)),
                                  random_clock_hour(), 8'($urandom)));
          end
          sent += HOURS_PER_SET + 6;
        end else begin
          // Loose requests of every kind.
          for (int n = 0; n < 10; n++) begin
            if ($urandom_range(0, 99) < 2) begin
              f = F_CLEAR;
            end else if ($urandom_range(0, 99) < 8) begin
              f = 4'($urandom_range(F_FIRST_UNUSED, F_LAST_UNUSED));
            end else begin
              f = 4'($urandom_range(F_READ, F_BOTTOM));
            end
            s = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, NUM_SETS - 1))
                                             : 4'($urandom_range(NUM_SETS, 15));
            send_request(make_req(f, s, random_hour(), 8'($urandom), random_clock_hour(),
                                  8'($urandom)));
          end
          sent += 10;
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Each result strobe is compared with the oldest expectation.
  always @(negedge clk) begin
    stats_outcome_t exp_o;
    if (!rst && done) begin
      transfers++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result value", 32'hx, 32'(value));
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (value !== exp_o.value) begin
          report_mismatch("value", 32'(exp_o.value), 32'(value));
        end
        if (flag !== exp_o.flag) begin
          report_mismatch("flag", 32'(exp_o.flag), 32'(flag));
        end
        if (bad_set !== exp_o.bad_set) begin
          report_mismatch("bad_set", 32'(exp_o.bad_set), 32'(bad_set));
        end
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || transfers != seen_transfers) begin
      seen_transfers = transfers;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    func <= F_READ;
    stats_set <= '0;
    hour <= '0;
    operand_value <= '0;
    current_hour <= '0;
    random_bits <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      sample_model[i] = UNSET_BYTE;
    end
    model_shift = SMOOTH_SHIFT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_contents();
    test_sample_access();
    test_smoothing_and_clear();
    test_random_traffic();

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> hourly_stats_table_engine.f
sv/hst_pkg.sv
sv/hst_ram.sv
sv/hourly_stats_table_engine.sv
verif/tb_hourly_stats_table_engine.sv
